// File: sv/utf8sd_pkg.sv
package utf8sd_pkg;

  localparam int unsigned CP_W       = 31;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PEND_W     = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CP_W-1:0] SUBST_CHAR = CP_W'(63);

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOS  = 1'b1
  } in_kind_t;

  typedef struct packed {
    logic             kind;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last;
  } out_item_t;

  // results of one decoded item, compacted so res0 is filled first
  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
  } dec_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             has_room;
  } fifo_stat_t;

endpackage

// File: sv/utf8_stream_decoder_unit.sv
// Legacy UTF-8 stream decoder: takes one byte (or end-of-string marker) per
// transfer and gives decoded code points of up to 31 bits, with '?' for
// malformed input. A byte is taken every cycle as long as results drain; a
// result passes the input holding register and then the result queue. A
// byte that cuts a sequence short gives two results if it is itself a
// single-byte character; these leave one per cycle through the single output
// port while out_ready is high. A four-entry result queue decouples the output
// side; the decode stage holds its byte while fewer than two slots are free.
module utf8_stream_decoder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utf8sd_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8sd_pkg::out_item_t out_item
);
  import utf8sd_pkg::*;

  in_item_t   item_r, item_nxt;
  logic       hold_r, hold_nxt;
  logic       fire;
  dec_res_t   dec_res;
  fifo_stat_t stat;

  assign fire     = hold_r && stat.has_room;
  assign in_ready = !hold_r || fire;

  always_comb begin
    hold_nxt = hold_r;
    item_nxt = item_r;
    if (in_valid && in_ready) begin
      hold_nxt = 1'b1;
      item_nxt = in_item;
    end else if (fire) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  utf8sd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (dec_res)
  );

  utf8sd_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire),
    .push_res (dec_res),
    .pop      (out_ready),
    .head     (out_item),
    .stat     (stat)
  );

  assign out_valid = (stat.count != '0);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_result_visible: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (dec_res.num != 2'd0) |=> out_valid)
    else $error("decoded result not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> hold_r && !stat.has_room)
    else $error("input stalled without cause");

  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (dec_res.num == 2'd2) |-> !dec_res.res0.last && dec_res.res0.replaced)
    else $error("bad first of two results");
`endif

endmodule

// File: sv/utf8sd_decode.sv
module utf8sd_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  utf8sd_pkg::in_item_t item,
  output utf8sd_pkg::dec_res_t res
);
  import utf8sd_pkg::*;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [CP_W-1:0]   pv_r, pv_nxt;
  logic              skip_r, skip_nxt;

  logic              cont;
  logic              fresh;
  logic [BYTE_W-1:0] b;
  logic [CP_W-1:0]   pv_shift;
  logic              pre_v, pre_repl, fr_v, fr_repl;
  logic [CP_W-1:0]   pre_cp, fr_cp;

  assign b        = item.data_byte;
  assign cont     = (b[7:6] == 2'b10);
  assign pv_shift = {pv_r[CP_W-7:0], b[5:0]};

  always_comb begin
    pend_nxt = pend_r;
    pv_nxt   = pv_r;
    skip_nxt = skip_r;
    fresh    = 1'b0;
    pre_v    = 1'b0;
    pre_cp   = SUBST_CHAR;
    pre_repl = 1'b1;
    fr_v     = 1'b0;
    fr_cp    = SUBST_CHAR;
    fr_repl  = 1'b1;

    if (item.kind == KIND_EOS) begin
      pre_v    = (pend_r != '0);
      pend_nxt = '0;
      pv_nxt   = '0;
      skip_nxt = 1'b0;
    end else begin
      if (pend_r != '0) begin
        if (cont) begin
          pend_nxt = pend_r - PEND_W'(1);
          if (pend_r == PEND_W'(1)) begin
            pre_v    = 1'b1;
            pre_cp   = pv_shift;
            pre_repl = 1'b0;
            pv_nxt   = '0;
          end else begin
            pv_nxt = pv_shift;
          end
        end else begin
          // sequence cut short, cutting byte starts afresh
          pre_v    = 1'b1;
          pend_nxt = '0;
          pv_nxt   = '0;
          fresh    = 1'b1;
        end
      end else if (skip_r) begin
        if (!cont) begin
          skip_nxt = 1'b0;
          fresh    = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end

      if (fresh) begin
        priority if (cont) begin
          fr_v     = 1'b1;
          skip_nxt = 1'b1;
        end else if (!b[7]) begin
          fr_v    = 1'b1;
          fr_cp   = CP_W'(b);
          fr_repl = 1'b0;
        end else if (b < 8'he0) begin
          pv_nxt   = CP_W'(b & 8'h1f);
          pend_nxt = PEND_W'(1);
        end else if (b < 8'hf0) begin
          pv_nxt   = CP_W'(b & 8'h0f);
          pend_nxt = PEND_W'(2);
        end else if (b < 8'hf8) begin
          pv_nxt   = CP_W'(b & 8'h07);
          pend_nxt = PEND_W'(3);
        end else if (b < 8'hfc) begin
          pv_nxt   = CP_W'(b & 8'h03);
          pend_nxt = PEND_W'(4);
        end else begin
          pv_nxt   = CP_W'(b & 8'h01);
          pend_nxt = PEND_W'(5);
        end
      end
    end
  end

  always_comb begin
    res.num             = {1'b0, pre_v} + {1'b0, fr_v};
    res.res0.code_point = pre_v ? pre_cp : fr_cp;
    res.res0.replaced   = pre_v ? pre_repl : fr_repl;
    res.res0.last       = !(pre_v && fr_v);
    res.res1.code_point = fr_cp;
    res.res1.replaced   = fr_repl;
    res.res1.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pv_r   <= '0;
      skip_r <= 1'b0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      pv_r   <= pv_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

// File: sv/utf8sd_res_fifo.sv
module utf8sd_res_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  utf8sd_pkg::dec_res_t   push_res,
  input  logic                   pop,
  output utf8sd_pkg::out_item_t  head,
  output utf8sd_pkg::fifo_stat_t stat
);
  import utf8sd_pkg::*;

  out_item_t        mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       push_num;
  logic             do_pop;

  assign push_num = push ? push_res.num : 2'd0;
  assign do_pop   = pop && (count_r != '0);

  always_comb begin
    wptr_nxt  = wptr_r + PTR_W'(push_num);
    rptr_nxt  = rptr_r + PTR_W'(do_pop);
    count_nxt = count_r + CNT_W'(push_num) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wptr_r] <= push_res.res0;
    end
    if (push_num == 2'd2) begin
      mem_r[wptr_r + PTR_W'(1)] <= push_res.res1;
    end
  end

  assign head          = mem_r[rptr_r];
  assign stat.count    = count_r;
  assign stat.has_room = (count_r <= CNT_W'(FIFO_DEPTH - 2));

endmodule
